// ===== rtl/m4i_pkg.sv =====
// m4i_pkg: shared types, constants and the term schedule of the 4x4 inverse
// used by matrix4_inverse; no dependencies
`timescale 1ns / 1ps

package m4i_pkg;

    localparam logic [3:0]  LAST_ELEM     = 4'd15;
    localparam logic [3:0]  TERM_COF_LAST = 4'd8;
    localparam logic [3:0]  TERM_DET_LAST = 4'd3;
    localparam logic [63:0] INT64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [31:0] THRESH_RESET  = 32'd4295;

    typedef enum logic [1:0] {
        BSRC_ELEM  = 2'd0,
        BSRC_MINOR = 2'd1,
        BSRC_COF   = 2'd2
    } t_bsrc;

    typedef struct packed {
        logic [3:0] a_addr;
        logic [3:0] b_addr;
        t_bsrc      b_src;
        logic [1:0] m_idx;
        logic       sub;
        logic       clr;
    } t_term;

    // n-th index of 0..3 with x skipped
    function automatic logic [1:0] skip_idx(logic [1:0] n, logic [1:0] x);
        logic [1:0] r;
        r = n + {1'b0, (n >= x)};
        return r;
    endfunction

    // one multiply term: cofactor k (adjugate row i = k[3:2], col j = k[1:0])
    // terms 0..5 build the three 2x2 minors, 6..8 the cofactor sum;
    // determinant phase terms 0..3 walk the first row
    function automatic t_term term_info(logic det_ph, logic [3:0] k, logic [3:0] t);
        t_term      r;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] r0;
        logic [1:0] r1;
        logic [1:0] c1;
        logic [1:0] c2;
        logic [1:0] n;
        r  = '0;
        i  = k[3:2];
        j  = k[1:0];
        c1 = skip_idx(2'd1, i);
        c2 = skip_idx(2'd2, i);
        n  = t[1:0] - 2'd2;
        if (det_ph) begin
            r.a_addr = {2'b00, t[1:0]};
            r.b_addr = {t[1:0], 2'b00};
            r.b_src  = BSRC_COF;
            r.clr    = (t == 4'd0);
        end else if (t < 4'd6) begin
            unique case (t[2:1])
                2'd0: begin
                    r0 = skip_idx(2'd1, j);
                    r1 = skip_idx(2'd2, j);
                end
                2'd1: begin
                    r0 = skip_idx(2'd0, j);
                    r1 = skip_idx(2'd2, j);
                end
                default: begin
                    r0 = skip_idx(2'd0, j);
                    r1 = skip_idx(2'd1, j);
                end
            endcase
            r.b_src = BSRC_ELEM;
            if (!t[0]) begin
                r.a_addr = {r0, c1};
                r.b_addr = {r1, c2};
                r.clr    = 1'b1;
            end else begin
                r.a_addr = {r0, c2};
                r.b_addr = {r1, c1};
                r.sub    = 1'b1;
            end
        end else begin
            r.a_addr = {skip_idx(n, j), skip_idx(2'd0, i)};
            r.b_src  = BSRC_MINOR;
            r.m_idx  = n;
            r.sub    = (n == 2'd1);
            r.clr    = (n == 2'd0);
        end
        return r;
    endfunction

endpackage

// ===== rtl/m4i_mac.sv =====
// m4i_mac: digit-serial signed multiply-accumulate, 8 bits of a per cycle
// depends on nothing outside this file
`timescale 1ns / 1ps

module m4i_mac #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_clr,
    input  logic                         i_sub,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [63:0]           i_b,
    output logic                         o_done,
    output logic signed [DATA_WIDTH+65:0] o_acc
);
    localparam int ACC_W = DATA_WIDTH + 66;
    localparam int ND    = (DATA_WIDTH + 7) / 8;
    localparam int AW    = ND * 8;
    localparam int CW    = $clog2(ND + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    r_amag;
    logic [ACC_W-1:0] r_bsh;
    logic             r_sub;
    logic [ACC_W-1:0] r_acc;
    logic [DATA_WIDTH-1:0] amag;
    logic [63:0]      bmag;
    logic [ACC_W+7:0] prod_full;
    logic [ACC_W-1:0] prod;

    assign amag      = i_a[DATA_WIDTH-1] ? DATA_WIDTH'(-i_a) : DATA_WIDTH'(i_a);
    assign bmag      = i_b[63] ? 64'(-i_b) : 64'(i_b);
    assign prod_full = r_amag[7:0] * r_bsh;
    assign prod      = prod_full[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ND);
                r_amag <= AW'(amag);
                r_bsh  <= ACC_W'(bmag);
                // sign of the product folds into add or subtract
                r_sub  <= i_sub ^ i_a[DATA_WIDTH-1] ^ i_b[63];
                if (i_clr) begin
                    r_acc <= '0;
                end
            end else if (r_busy) begin
                r_acc  <= r_sub ? r_acc - prod : r_acc + prod;
                r_amag <= r_amag >> 8;
                r_bsh  <= r_bsh << 8;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = $signed(r_acc);

endmodule

// ===== rtl/m4i_div.sv =====
// m4i_div: restoring bit-serial divider, (num << FRAC_BITS) / den, saturated
// to a signed DATA_WIDTH result; depends on nothing outside this file
`timescale 1ns / 1ps

module m4i_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [63:0]           i_num,
    input  logic [63:0]           i_den,
    input  logic                  i_neg,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quot
);
    localparam int NUM_W = 64 + FRAC_BITS;
    localparam int CW    = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_q;
    logic [63:0]      r_rem;
    logic [63:0]      r_den;
    logic             r_neg;
    logic [64:0]      rem_sh;
    logic             ge;
    logic [64:0]      rem_sub;
    logic [NUM_W-1:0] limit;
    logic [NUM_W-1:0] q_sat;
    logic [DATA_WIDTH-1:0] q_lo;

    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_num  <= {i_num, {FRAC_BITS{1'b0}}};
                r_q    <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_neg;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[63:0] : rem_sh[63:0];
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // negative side may reach one step further
    assign limit  = (NUM_W'(1) << (DATA_WIDTH - 1)) - (r_neg ? NUM_W'(0) : NUM_W'(1));
    assign q_sat  = (r_q > limit) ? limit : r_q;
    assign q_lo   = q_sat[DATA_WIDTH-1:0];
    assign o_quot = r_neg ? DATA_WIDTH'(-q_lo) : q_lo;
    assign o_done = r_done;

endmodule

// ===== rtl/matrix4_inverse.sv =====
// matrix4_inverse: 4x4 fixed-point inverse by the adjugate, one shared
// multiply-accumulate unit and one serial divider under a sequencer
// sequence: 16 input transactions at one per cycle while loading, then
// 148 multiply terms, the cofactor and determinant finish steps, and per
// output a divider run unless singular; not ready from the sixteenth
// input until the last output is taken
// reset: synchronous active-low, clears control and sets the threshold to 4295
`timescale 1ns / 1ps

module matrix4_inverse #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [31:0]                         i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // matrix_element
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // inverse_element
    output logic [((DATA_WIDTH+7)/8)*8-1:0]     o_m_tdata,
    // is_singular
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);
    localparam int ACC_W = DATA_WIDTH + 66;
    localparam int TD_W  = ((DATA_WIDTH + 7) / 8) * 8;

    typedef enum logic [3:0] {
        S_LOAD, S_RD_A, S_RD_B, S_MUL_GO, S_MUL_WAIT, S_COF_FIN,
        S_DET_FIN, S_OUT_RD, S_OUT_DIV, S_OUT_WAIT, S_OUT_HOLD
    } t_state;

    t_state r_state;
    logic [31:0] r_thr;
    logic [3:0]  r_cnt;
    logic [3:0]  r_k;
    logic [3:0]  r_t;
    logic        r_det_ph;
    logic signed [DATA_WIDTH-1:0] r_op_a;
    logic signed [63:0] r_minor [3];
    logic        r_det_neg;
    logic [63:0] r_mag;
    logic        r_sing;
    logic        r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_data;
    logic        r_out_last;

    logic signed [DATA_WIDTH-1:0] elem_mem [16];
    logic signed [63:0]           cof_mem  [16];
    logic signed [DATA_WIDTH-1:0] r_elem_rd;
    logic signed [63:0]           r_cof_rd;
    logic [3:0]  elem_raddr;
    logic [3:0]  cof_raddr;
    logic        in_acc;
    logic        out_acc;

    m4i_pkg::t_term term;
    logic signed [63:0] b_sel;
    logic        mac_start;
    logic        mac_done;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [ACC_W-1:0] acc_fin;
    logic [ACC_W-64:0] hi_raw;
    logic [ACC_W-64:0] hi_fin;
    logic [63:0] sat_raw;
    logic [63:0] sat_fin;
    logic [63:0] det_mag;
    logic        det_sing;
    logic        div_start;
    logic        div_done;
    logic [DATA_WIDTH-1:0] div_quot;
    logic [63:0] cof_mag;

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = r_out_valid && i_m_tready;
    assign term    = m4i_pkg::term_info(r_det_ph, r_k, r_t);

    always_comb begin
        elem_raddr = term.a_addr;
        if (r_state == S_RD_B) begin
            elem_raddr = term.b_addr;
        end
        cof_raddr = term.b_addr;
        if (r_state == S_OUT_RD) begin
            cof_raddr = r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            elem_mem[r_cnt] <= $signed(i_s_tdata[DATA_WIDTH-1:0]);
        end
        r_elem_rd <= elem_mem[elem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_COF_FIN) begin
            cof_mem[r_k] <= sat_fin;
        end
        r_cof_rd <= cof_mem[cof_raddr];
    end

    always_comb begin
        unique case (term.b_src)
            m4i_pkg::BSRC_ELEM:  b_sel = 64'(r_elem_rd);
            m4i_pkg::BSRC_MINOR: begin
                unique case (term.m_idx)
                    2'd0:    b_sel = r_minor[0];
                    2'd1:    b_sel = r_minor[1];
                    default: b_sel = r_minor[2];
                endcase
            end
            m4i_pkg::BSRC_COF:   b_sel = r_cof_rd;
            default:             b_sel = r_cof_rd;
        endcase
    end

    assign mac_start = (r_state == S_MUL_GO);

    m4i_mac #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_clr   (term.clr),
        .i_sub   (term.sub),
        .i_a     (r_op_a),
        .i_b     (b_sel),
        .o_done  (mac_done),
        .o_acc   (acc)
    );

    // minors saturate raw; cofactor and determinant drop FRAC_BITS first,
    // odd cofactor positions take the adjugate sign before saturation
    assign acc_sh  = acc >>> FRAC_BITS;
    assign acc_fin = (!r_det_ph && (r_k[2] ^ r_k[0])) ? -acc_sh : acc_sh;
    assign hi_raw  = acc[ACC_W-1:63];
    assign hi_fin  = acc_fin[ACC_W-1:63];
    assign sat_raw = ((&hi_raw) || !(|hi_raw)) ? acc[63:0] :
                     (acc[ACC_W-1] ? m4i_pkg::INT64_MIN : m4i_pkg::INT64_MAX);
    assign sat_fin = ((&hi_fin) || !(|hi_fin)) ? acc_fin[63:0] :
                     (acc_fin[ACC_W-1] ? m4i_pkg::INT64_MIN : m4i_pkg::INT64_MAX);
    assign det_mag  = sat_fin[63] ? 64'(-sat_fin) : sat_fin;
    assign det_sing = (det_mag == 64'd0) || (det_mag < {32'd0, r_thr});

    assign cof_mag   = r_cof_rd[63] ? 64'(-r_cof_rd) : 64'(r_cof_rd);
    assign div_start = (r_state == S_OUT_DIV) && !r_sing;

    m4i_div #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (cof_mag),
        .i_den   (r_mag),
        .i_neg   (r_cof_rd[63] ^ r_det_neg),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= m4i_pkg::THRESH_RESET;
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_k         <= '0;
            r_t         <= '0;
            r_det_ph    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == m4i_pkg::LAST_ELEM) begin
                            r_k      <= '0;
                            r_t      <= '0;
                            r_det_ph <= 1'b0;
                            r_state  <= S_RD_A;
                        end
                    end
                end
                S_RD_A: r_state <= S_RD_B;
                S_RD_B: begin
                    r_op_a  <= r_elem_rd;
                    r_state <= S_MUL_GO;
                end
                S_MUL_GO: r_state <= S_MUL_WAIT;
                S_MUL_WAIT: begin
                    if (mac_done) begin
                        if (r_det_ph) begin
                            r_t     <= r_t + 1'b1;
                            r_state <= (r_t == m4i_pkg::TERM_DET_LAST) ? S_DET_FIN : S_RD_A;
                        end else begin
                            if (r_t[0] && r_t < 4'd6) begin
                                r_minor[r_t[2:1]] <= $signed(sat_raw);
                            end
                            r_t     <= r_t + 1'b1;
                            r_state <= (r_t == m4i_pkg::TERM_COF_LAST) ? S_COF_FIN : S_RD_A;
                        end
                    end
                end
                S_COF_FIN: begin
                    r_t <= '0;
                    r_k <= r_k + 1'b1;
                    if (r_k == m4i_pkg::LAST_ELEM) begin
                        r_det_ph <= 1'b1;
                    end
                    r_state <= S_RD_A;
                end
                S_DET_FIN: begin
                    r_det_neg <= sat_fin[63];
                    r_mag     <= det_mag;
                    r_sing    <= det_sing;
                    r_k       <= '0;
                    r_state   <= S_OUT_RD;
                end
                S_OUT_RD: r_state <= S_OUT_DIV;
                S_OUT_DIV: begin
                    if (r_sing) begin
                        r_out_data  <= '0;
                        r_out_last  <= (r_k == m4i_pkg::LAST_ELEM);
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT_HOLD;
                    end else begin
                        r_state <= S_OUT_WAIT;
                    end
                end
                S_OUT_WAIT: begin
                    if (div_done) begin
                        r_out_data  <= div_quot;
                        r_out_last  <= (r_k == m4i_pkg::LAST_ELEM);
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT_HOLD;
                    end
                end
                S_OUT_HOLD: begin
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        r_k         <= r_k + 1'b1;
                        r_state     <= (r_k == m4i_pkg::LAST_ELEM) ? S_LOAD : S_OUT_RD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TD_W'(r_out_data);
    assign o_m_tuser  = r_sing;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== bench/matrix4_inverse_checker.sv =====
// matrix4_inverse_checker: watches both streams and the threshold writes of
// matrix4_inverse, predicts each inverse element and compares; uses m4i_pkg
`timescale 1ns / 1ps

module matrix4_inverse_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [31:0] value;
        logic        singular;
        logic        last;
    } t_inv_elem;

    logic signed [63:0] elems[16];
    logic [3:0]         load_cnt;
    logic [31:0]        threshold;
    t_inv_elem          inverse_q[$];

    function automatic logic signed [127:0] mul_wide(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [127:0] x;
        logic signed [127:0] y;
        x = a;
        y = b;
        return x * y;
    endfunction

    function automatic logic signed [63:0] clamp64(logic signed [127:0] x);
        if (x[127:63] == '0 || x[127:63] == '1) return x[63:0];
        return x[127] ? m4i_pkg::INT64_MIN : m4i_pkg::INT64_MAX;
    endfunction

    function automatic logic signed [63:0] minor2(int r0, int r1, int c0, int c1);
        return clamp64(mul_wide(elems[r0*4+c0], elems[r1*4+c1])
                     - mul_wide(elems[r0*4+c1], elems[r1*4+c0]));
    endfunction

    // adjugate entry (i, j): minor without row j and column i
    function automatic logic signed [63:0] cofactor(int i, int j);
        int                  rw[3];
        int                  cl[3];
        int                  n;
        logic signed [127:0] acc;
        n = 0;
        for (int k = 0; k < 4; k++) if (k != j) begin rw[n] = k; n++; end
        n = 0;
        for (int k = 0; k < 4; k++) if (k != i) begin cl[n] = k; n++; end
        acc = mul_wide(elems[rw[0]*4+cl[0]], minor2(rw[1], rw[2], cl[1], cl[2]))
            - mul_wide(elems[rw[1]*4+cl[0]], minor2(rw[0], rw[2], cl[1], cl[2]))
            + mul_wide(elems[rw[2]*4+cl[0]], minor2(rw[0], rw[1], cl[1], cl[2]));
        acc = acc >>> 16;
        if ((i + j) % 2 == 1) acc = -acc;
        return clamp64(acc);
    endfunction

    function automatic logic [31:0] scaled_quotient(logic signed [63:0] c,
                                                    logic [63:0] d, logic neg);
        logic [63:0]  mag;
        logic [127:0] q;
        logic [127:0] limit;
        mag   = c[63] ? 64'(-c) : 64'(c);
        q     = ({64'd0, mag} << 16) / {64'd0, d};
        limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > limit) q = limit;
        return neg ? 32'(-q) : q[31:0];
    endfunction

    task automatic predict_inverse();
        logic signed [63:0]  cof[16];
        logic signed [127:0] acc;
        logic signed [63:0]  det;
        logic [63:0]         det_mag;
        logic                sing;
        t_inv_elem           r;
        acc = '0;
        for (int k = 0; k < 16; k++) cof[k] = cofactor(k / 4, k % 4);
        for (int k = 0; k < 4; k++) acc += mul_wide(elems[k], cof[k*4]);
        det     = clamp64(acc >>> 16);
        det_mag = det[63] ? 64'(-det) : 64'(det);
        sing    = (det_mag == 0) || (det_mag < {32'd0, threshold});
        for (int k = 0; k < 16; k++) begin
            r.value    = sing ? 32'd0 : scaled_quotient(cof[k], det_mag,
                                                        cof[k][63] != det[63]);
            r.singular = sing;
            r.last     = (k == 15);
            inverse_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_inv_elem want;
        if (!i_rst_n) begin
            load_cnt  <= '0;
            threshold <= m4i_pkg::THRESH_RESET;
        end else begin
            if (i_cfg_we) threshold <= i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                elems[load_cnt] = {{32{i_s_tdata[31]}}, i_s_tdata};
                load_cnt <= load_cnt + 4'd1;
                if (load_cnt == m4i_pkg::LAST_ELEM) predict_inverse();
            end
            if (i_m_tvalid && i_m_tready) begin
                if (inverse_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected output transaction data=%h", $time,
                                 i_m_tdata);
                end else begin
                    want = inverse_q.pop_front();
                    if (i_m_tdata !== want.value || i_m_tuser !== want.singular
                        || i_m_tlast !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch exp %h/%b/%b got %h/%b/%b", $time,
                                     want.value, want.singular, want.last,
                                     i_m_tdata, i_m_tuser, i_m_tlast);
                    end
                end
            end
        end
        o_pending = inverse_q.size();
    end

endmodule

// ===== bench/matrix4_inverse_tb.sv =====
// matrix4_inverse_tb: stimulus and verdict for matrix4_inverse; the checker
// in matrix4_inverse_checker.sv predicts and compares every output
`timescale 1ns / 1ps

module matrix4_inverse_tb;
    localparam logic [31:0] ONE = 32'h0001_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;       // matrix_element
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;            // inverse_element
    logic        o_m_tuser;            // is_singular
    logic        o_m_tlast;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    always #5 i_clk = ~i_clk;

    matrix4_inverse u_top (.*);

    matrix4_inverse_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .i_m_tlast(o_m_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_element(logic [31:0] value);
        logic rdy;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        forever begin
            #1 rdy = o_s_tready;
            @(posedge i_clk);
            if (rdy) break;
            @(negedge i_clk);
        end
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    // idle between matrices, then let the block settle before a write
    task automatic write_threshold(logic [31:0] value);
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] random_element(int kind);
        case (kind)
            0:       return 32'($signed($urandom_range(8 * ONE)) - $signed(4 * ONE));
            1:       return $urandom();
            default: return 32'($signed($urandom_range(2 * ONE)) - $signed(ONE));
        endcase
    endfunction

    task automatic send_matrix(logic [31:0] m[16]);
        for (int k = 0; k < 16; k++) send_element(m[k]);
        drop_valid();
    endtask

    initial begin
        logic [31:0] m[16];
        int          kind;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity, default threshold
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? ONE : 32'd0;
        send_matrix(m);
        // tiny diagonal with extreme off-diagonal corners: saturating inverse
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'd1 : 32'd0;
        m[3]  = 32'h7FFF_FFFF;
        m[12] = 32'h8000_0000;
        write_threshold(32'd0);
        send_matrix(m);
        // all zeros at threshold zero is still singular
        for (int k = 0; k < 16; k++) m[k] = '0;
        send_matrix(m);

        for (int n = 0; n < 10; n++) begin
            send_idle_pct  = (n % 4 == 1 || n % 4 == 3) ? 85 : 0;
            recv_stall_pct = (n % 4 == 2 || n % 4 == 3) ? 85 : 0;
            if (n % 4 == 3) begin
                send_idle_pct  = 9;
                recv_stall_pct = 9;
            end
            if (n == 3) write_threshold(32'hFFFF_FFFF);
            if (n == 6) write_threshold($urandom());
            if (n == 9) write_threshold(32'd4295);
            kind = $urandom_range(5);
            for (int k = 0; k < 16; k++)
                m[k] = random_element(kind > 2 ? 0 : kind);
            if (kind == 5) for (int k = 0; k < 4; k++) m[8 + k] = m[4 + k];
            if (kind == 4) for (int k = 0; k < 16; k += 5) m[k] = m[k] + 8 * ONE;
            send_matrix(m);
        end

        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== matrix4_inverse.f =====
rtl/m4i_pkg.sv
rtl/m4i_mac.sv
rtl/m4i_div.sv
rtl/matrix4_inverse.sv
bench/matrix4_inverse_checker.sv
bench/matrix4_inverse_tb.sv
